@@ src/nfad_pkg.sv @@
// Package: command codes, field widths and register reset values for the atom color block.
package nfad_pkg;

   // command codes
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_LOAD  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   // register indexes
   localparam logic [2:0] REG_MAX_DIST   = 3'd0;
   localparam logic [2:0] REG_NEAR_RED   = 3'd1;
   localparam logic [2:0] REG_NEAR_GREEN = 3'd2;
   localparam logic [2:0] REG_NEAR_BLUE  = 3'd3;
   localparam logic [2:0] REG_FAR_RED    = 3'd4;
   localparam logic [2:0] REG_FAR_GREEN  = 3'd5;
   localparam logic [2:0] REG_FAR_BLUE   = 3'd6;

   localparam int DEF_MAX_ATOMS = 256;
   localparam int POS_W  = 24;
   localparam int MOL_W  = 16;
   localparam int IDX_W  = 8;
   localparam int DIST_W = 16;
   localparam int CHAN_W = 8;
   localparam int ADDR_W = 5;

   localparam logic [DIST_W-1:0] RST_MAX_DIST   = 16'd2560;
   localparam logic [CHAN_W-1:0] RST_NEAR_RED   = 8'd255;
   localparam logic [CHAN_W-1:0] RST_NEAR_GREEN = 8'd0;
   localparam logic [CHAN_W-1:0] RST_NEAR_BLUE  = 8'd0;
   localparam logic [CHAN_W-1:0] RST_FAR_RED    = 8'd0;
   localparam logic [CHAN_W-1:0] RST_FAR_GREEN  = 8'd255;
   localparam logic [CHAN_W-1:0] RST_FAR_BLUE   = 8'd0;

   typedef struct packed {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic [POS_W-1:0] z;
      logic [MOL_W-1:0] mol;
   } atom_type;

endpackage

@@ src/nearest_foreign_atom_distance_color.sv @@
// Top level: atom table, nearest foreign atom search, square root and color ramp.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | command, pos_x/y/z, molecule_id, atom_index
//  rsp     | out       | rsp_valid / rsp_stall | red, green, blue, nearest_distance, found, overflowed
//  csr     | in/out    | psel/penable/pready   | paddr, pwdata, prdata
//
// Clear and load do not stall. A query of a stored index holds req_stall while the shared multiplier
// runs three squares per atom, then a 26-step square root and three 8-step divisions for the color.
// An unknown index skips the search and root. A result held by rsp_stall adds its wait. Reset clears
// the table count and overflow flag and sets the registers to their reset values. A pending result
// does not block clear or load.
module nearest_foreign_atom_distance_color #(
   parameter int MAX_ATOMS = nfad_pkg::DEF_MAX_ATOMS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_command,
   input  logic signed [nfad_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [nfad_pkg::POS_W-1:0] req_pos_y,
   input  logic signed [nfad_pkg::POS_W-1:0] req_pos_z,
   input  logic [nfad_pkg::MOL_W-1:0]    req_molecule_id,
   input  logic [nfad_pkg::IDX_W-1:0]    req_atom_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [nfad_pkg::CHAN_W-1:0]   rsp_red,
   output logic [nfad_pkg::CHAN_W-1:0]   rsp_green,
   output logic [nfad_pkg::CHAN_W-1:0]   rsp_blue,
   output logic [nfad_pkg::DIST_W-1:0]   rsp_nearest_distance,
   output logic                          rsp_found,
   output logic                          rsp_overflowed,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [nfad_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import nfad_pkg::*;

   localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
   localparam int CW = $clog2(MAX_ATOMS + 1);
   localparam int IW = (AW > IDX_W) ? AW : IDX_W;
   localparam int CIW = (CW > IW) ? CW : IW;
   localparam int DW = POS_W + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;
   localparam int RW = SW / 2 + SW % 2;
   localparam int VW = 2 * RW;
   localparam int MW = RW + 2;
   localparam int NW = CHAN_W + DIST_W;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_TGT  = 4'd1;
   localparam logic [3:0] S_ITER = 4'd2;
   localparam logic [3:0] S_SQRT = 4'd3;
   localparam logic [3:0] S_CLIP = 4'd4;
   localparam logic [3:0] S_NUM0 = 4'd5;
   localparam logic [3:0] S_NUM1 = 4'd6;
   localparam logic [3:0] S_DIV  = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   // configuration registers
   logic [DIST_W-1:0] max_dist_ff;
   logic [CHAN_W-1:0] near_r_ff, near_g_ff, near_b_ff, far_r_ff, far_g_ff, far_b_ff;
   logic              cfg_wr;
   logic [2:0]        cfg_idx;

   assign pready  = 1'b1;
   assign cfg_wr  = psel & penable & pwrite;
   assign cfg_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff <= RST_MAX_DIST;
         near_r_ff   <= RST_NEAR_RED;
         near_g_ff   <= RST_NEAR_GREEN;
         near_b_ff   <= RST_NEAR_BLUE;
         far_r_ff    <= RST_FAR_RED;
         far_g_ff    <= RST_FAR_GREEN;
         far_b_ff    <= RST_FAR_BLUE;
      end else if (cfg_wr) begin
         case (cfg_idx)
            REG_MAX_DIST:   max_dist_ff <= pwdata[DIST_W-1:0];
            REG_NEAR_RED:   near_r_ff   <= pwdata[CHAN_W-1:0];
            REG_NEAR_GREEN: near_g_ff   <= pwdata[CHAN_W-1:0];
            REG_NEAR_BLUE:  near_b_ff   <= pwdata[CHAN_W-1:0];
            REG_FAR_RED:    far_r_ff    <= pwdata[CHAN_W-1:0];
            REG_FAR_GREEN:  far_g_ff    <= pwdata[CHAN_W-1:0];
            REG_FAR_BLUE:   far_b_ff    <= pwdata[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (cfg_idx)
         REG_MAX_DIST:   prdata = {16'd0, max_dist_ff};
         REG_NEAR_RED:   prdata = {24'd0, near_r_ff};
         REG_NEAR_GREEN: prdata = {24'd0, near_g_ff};
         REG_NEAR_BLUE:  prdata = {24'd0, near_b_ff};
         REG_FAR_RED:    prdata = {24'd0, far_r_ff};
         REG_FAR_GREEN:  prdata = {24'd0, far_g_ff};
         REG_FAR_BLUE:   prdata = {24'd0, far_b_ff};
         default:        prdata = 32'd0;
      endcase
   end

   // control and datapath registers
   logic [3:0]        state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [CW-1:0]     i_ff, i_in;
   logic [2:0]        ph_ff, ph_in;
   logic              found_ff, found_in;
   logic              any_ff, any_in;
   logic              skip_ff, skip_in;
   atom_type          tgt_ff, tgt_in;
   logic [DW-1:0]     ax_ff, ay_ff, az_ff, ax_in, ay_in, az_in;
   logic [SW-1:0]     acc_ff, acc_in;
   logic [SW-1:0]     min_ff, min_in;
   logic [VW-1:0]     sv_ff, sv_in;
   logic [MW-1:0]     rem_ff, rem_in;
   logic [RW-1:0]     root_ff, root_in;
   logic [4:0]        step_ff, step_in;
   logic [DIST_W-1:0] d_ff, d_in;
   logic [1:0]        ch_ff, ch_in;
   logic [NW-1:0]     drem_ff, drem_in;
   logic [CHAN_W-1:0] q_ff, q_in;
   logic [CHAN_W-1:0] col_ff [3];
   logic [CHAN_W-1:0] col_in [3];
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0] out_r_ff, out_g_ff, out_b_ff, out_r_in, out_g_in, out_b_in;
   logic [DIST_W-1:0] out_d_ff, out_d_in;
   logic              out_f_ff, out_o_ff, out_f_in, out_o_in;

   // atom memory
   atom_type mem [MAX_ATOMS];
   atom_type rd_ff;
   logic [AW-1:0] rd_addr;
   logic          mem_we;
   atom_type      wr_atom;

   logic accept;
   logic [CIW-1:0] idx_w, count_w;

   assign accept  = req_valid & ~req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign idx_w   = CIW'(req_atom_index);
   assign count_w = CIW'(count_ff);
   assign wr_atom = '{x: req_pos_x, y: req_pos_y, z: req_pos_z, mol: req_molecule_id};
   assign mem_we  = accept && (req_command == CMD_LOAD) && (count_ff < CW'(MAX_ATOMS));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[AW-1:0]] <= wr_atom;
      end
      rd_ff <= mem[rd_addr];
   end

   // shared multiplier
   logic [DW-1:0] mul_a, mul_b;
   logic [PW-1:0] prod;
   assign prod = mul_a * mul_b;

   // near and far for the channel in work
   logic [CHAN_W-1:0] near_c, far_c;
   always_comb begin
      case (ch_ff)
         2'd0:    begin near_c = near_r_ff; far_c = far_r_ff; end
         2'd1:    begin near_c = near_g_ff; far_c = far_g_ff; end
         default: begin near_c = near_b_ff; far_c = far_b_ff; end
      endcase
   end

   // signed coordinate differences; the search keeps their magnitudes
   logic signed [DW-1:0] dx, dy, dz;
   assign dx = $signed({rd_ff.x[POS_W-1], rd_ff.x}) - $signed({tgt_ff.x[POS_W-1], tgt_ff.x});
   assign dy = $signed({rd_ff.y[POS_W-1], rd_ff.y}) - $signed({tgt_ff.y[POS_W-1], tgt_ff.y});
   assign dz = $signed({rd_ff.z[POS_W-1], rd_ff.z}) - $signed({tgt_ff.z[POS_W-1], tgt_ff.z});

   // square root and division steps
   logic [MW-1:0]     sq_rem, sq_trial;
   logic [NW-1:0]     dv_trial;
   logic [2:0]        dv_k;
   assign sq_rem   = {rem_ff[MW-3:0], sv_ff[VW-1 -: 2]};
   assign sq_trial = {root_ff, 2'b01};
   assign dv_k     = step_ff[2:0];
   assign dv_trial = NW'({max_dist_ff, 7'd0} >> (3'd7 - dv_k));

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      i_in        = i_ff;
      ph_in       = ph_ff;
      found_in    = found_ff;
      any_in      = any_ff;
      skip_in     = skip_ff;
      tgt_in      = tgt_ff;
      ax_in       = ax_ff;
      ay_in       = ay_ff;
      az_in       = az_ff;
      acc_in      = acc_ff;
      min_in      = min_ff;
      sv_in       = sv_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      step_in     = step_ff;
      d_in        = d_ff;
      ch_in       = ch_ff;
      drem_in     = drem_ff;
      q_in        = q_ff;
      col_in      = col_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      out_r_in    = out_r_ff;
      out_g_in    = out_g_ff;
      out_b_in    = out_b_ff;
      out_d_in    = out_d_ff;
      out_f_in    = out_f_ff;
      out_o_in    = out_o_ff;
      rd_addr     = i_ff[AW-1:0];
      mul_a       = ax_ff;
      mul_b       = ax_ff;

      case (state_ff)
         S_IDLE: begin
            rd_addr = idx_w[AW-1:0];
            if (accept) begin
               case (req_command)
                  CMD_CLEAR: begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                  end
                  CMD_LOAD: begin
                     if (count_ff < CW'(MAX_ATOMS)) begin
                        count_in = count_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  CMD_QUERY: begin
                     any_in      = 1'b0;
                     i_in        = '0;
                     ph_in       = '0;
                     if (idx_w < count_w) begin
                        found_in = 1'b1;
                        state_in = S_TGT;
                     end else begin
                        found_in = 1'b0;
                        state_in = S_CLIP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_TGT: begin
            tgt_in   = rd_ff;
            state_in = S_ITER;
         end
         S_ITER: begin
            case (ph_ff)
               3'd0: ph_in = 3'd1;
               3'd1: begin
                  // capture magnitudes and the same-molecule flag
                  ax_in   = dx[DW-1] ? DW'(-dx) : DW'(dx);
                  ay_in   = dy[DW-1] ? DW'(-dy) : DW'(dy);
                  az_in   = dz[DW-1] ? DW'(-dz) : DW'(dz);
                  skip_in = (rd_ff.mol == tgt_ff.mol);
                  ph_in   = 3'd2;
               end
               3'd2: begin
                  acc_in = SW'(prod);
                  ph_in  = 3'd3;
               end
               3'd3: begin
                  mul_a  = ay_ff;
                  mul_b  = ay_ff;
                  acc_in = acc_ff + SW'(prod);
                  ph_in  = 3'd4;
               end
               3'd4: begin
                  mul_a  = az_ff;
                  mul_b  = az_ff;
                  acc_in = acc_ff + SW'(prod);
                  ph_in  = 3'd5;
               end
               default: begin
                  // keep the smallest squared length of a foreign atom
                  if (!skip_ff && (!any_ff || acc_ff < min_ff)) begin
                     min_in = acc_ff;
                     any_in = 1'b1;
                  end
                  ph_in = 3'd0;
                  i_in  = i_ff + 1'b1;
                  if (i_ff + 1'b1 == count_ff) begin
                     sv_in    = VW'(any_in ? min_in : '0);
                     rem_in   = '0;
                     root_in  = '0;
                     step_in  = '0;
                     state_in = S_SQRT;
                  end
               end
            endcase
         end
         S_SQRT: begin
            // two bits of the radicand each step
            sv_in = sv_ff << 2;
            if (sq_rem >= sq_trial) begin
               rem_in  = sq_rem - sq_trial;
               root_in = {root_ff[RW-2:0], 1'b1};
            end else begin
               rem_in  = sq_rem;
               root_in = {root_ff[RW-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 5'(RW - 1)) begin
               state_in = S_CLIP;
            end
         end
         S_CLIP: begin
            if (!found_ff || !any_ff || root_ff > RW'(max_dist_ff)) begin
               d_in = max_dist_ff;
            end else begin
               d_in = root_ff[DIST_W-1:0];
            end
            ch_in    = '0;
            state_in = S_NUM0;
         end
         S_NUM0: begin
            mul_a    = DW'(near_c);
            mul_b    = DW'(max_dist_ff - d_ff);
            acc_in   = SW'(prod);
            state_in = S_NUM1;
         end
         S_NUM1: begin
            mul_a    = DW'(far_c);
            mul_b    = DW'(d_ff);
            drem_in  = NW'(acc_ff + SW'(prod));
            q_in     = '0;
            step_in  = 5'd7;
            state_in = S_DIV;
         end
         S_DIV: begin
            // restoring division, one quotient bit per step
            if (drem_ff >= dv_trial) begin
               drem_in = drem_ff - dv_trial;
               q_in    = q_ff | CHAN_W'(8'd1 << dv_k);
            end
            step_in = step_ff - 1'b1;
            if (dv_k == 3'd0) begin
               col_in[ch_ff] = (max_dist_ff == '0) ? near_c : q_in;
               if (ch_ff == 2'd2) begin
                  state_in = S_OUT;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = S_NUM0;
               end
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               out_r_in     = col_ff[0];
               out_g_in     = col_ff[1];
               out_b_in     = col_ff[2];
               out_d_in     = d_ff;
               out_f_in     = found_ff;
               out_o_in     = ovf_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         ph_ff        <= '0;
         step_ff      <= '0;
         ch_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         i_ff         <= i_in;
         ph_ff        <= ph_in;
         step_ff      <= step_in;
         ch_ff        <= ch_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff    <= found_in;
      any_ff      <= any_in;
      skip_ff     <= skip_in;
      tgt_ff      <= tgt_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      az_ff       <= az_in;
      acc_ff      <= acc_in;
      min_ff      <= min_in;
      sv_ff       <= sv_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      d_ff        <= d_in;
      drem_ff     <= drem_in;
      q_ff        <= q_in;
      col_ff      <= col_in;
      out_r_ff    <= out_r_in;
      out_g_ff    <= out_g_in;
      out_b_ff    <= out_b_in;
      out_d_ff    <= out_d_in;
      out_f_ff    <= out_f_in;
      out_o_ff    <= out_o_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_red              = out_r_ff;
   assign rsp_green            = out_g_ff;
   assign rsp_blue             = out_b_ff;
   assign rsp_nearest_distance = out_d_ff;
   assign rsp_found            = out_f_ff;
   assign rsp_overflowed       = out_o_ff;

endmodule

@@ bench/tb.sv @@
// Testbench for the nearest foreign atom distance color block: random atom tables and queries.
module tb;
   import nfad_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = DEF_MAX_ATOMS;

   typedef struct {
      logic [1:0]       command;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] pos_z;
      logic [MOL_W-1:0] molecule_id;
      logic [IDX_W-1:0] atom_index;
   } atom_cmd_type;

   typedef struct {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [DIST_W-1:0] nearest_distance;
      logic              found;
      logic              overflowed;
   } atom_color_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_command = '0;
   logic signed [POS_W-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [MOL_W-1:0] req_molecule_id = '0;
   logic [IDX_W-1:0] req_atom_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [CHAN_W-1:0] rsp_red, rsp_green, rsp_blue;
   logic [DIST_W-1:0] rsp_nearest_distance;
   logic rsp_found, rsp_overflowed;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   nearest_foreign_atom_distance_color i_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow of the block's table and registers
   logic signed [POS_W-1:0] shadow_x [TABLE_DEPTH];
   logic signed [POS_W-1:0] shadow_y [TABLE_DEPTH];
   logic signed [POS_W-1:0] shadow_z [TABLE_DEPTH];
   logic [MOL_W-1:0] shadow_mol [TABLE_DEPTH];
   int unsigned shadow_count = 0;
   bit shadow_overflow = 1'b0;
   logic [DIST_W-1:0] cap_dist = RST_MAX_DIST;
   logic [CHAN_W-1:0] near_rgb [3] = '{RST_NEAR_RED, RST_NEAR_GREEN, RST_NEAR_BLUE};
   logic [CHAN_W-1:0] far_rgb [3] = '{RST_FAR_RED, RST_FAR_GREEN, RST_FAR_BLUE};

   atom_cmd_type pending_cmds [$];
   atom_color_type expected_colors [$];
   int error_count = 0;
   bit quiet_phase = 1'b0;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic logic [CHAN_W-1:0] blend(int unsigned nc, int unsigned fc,
                                                 int unsigned d, int unsigned span);
      if (span == 0) return nc[CHAN_W-1:0];
      return CHAN_W'((longint'(nc) * (span - d) + longint'(fc) * d) / span);
   endfunction

   // apply one accepted transaction to the shadow state, queue a color if a query
   function automatic void predict_color(atom_cmd_type c);
      atom_color_type r;
      longint best, dx, dy, dz;
      longint unsigned len;
      int unsigned d;
      case (c.command)
         CMD_CLEAR: begin
            shadow_count = 0;
            shadow_overflow = 1'b0;
         end
         CMD_LOAD: begin
            if (shadow_count < TABLE_DEPTH) begin
               shadow_x[shadow_count] = c.pos_x;
               shadow_y[shadow_count] = c.pos_y;
               shadow_z[shadow_count] = c.pos_z;
               shadow_mol[shadow_count] = c.molecule_id;
               shadow_count++;
            end else begin
               shadow_overflow = 1'b1;
            end
         end
         CMD_QUERY: begin
            best = cap_dist;
            r.found = 1'b0;
            if (c.atom_index < shadow_count) begin
               r.found = 1'b1;
               for (int i = 0; i < shadow_count; i++) begin
                  if (shadow_mol[i] == shadow_mol[c.atom_index]) continue;
                  dx = longint'(shadow_x[i]) - longint'(shadow_x[c.atom_index]);
                  dy = longint'(shadow_y[i]) - longint'(shadow_y[c.atom_index]);
                  dz = longint'(shadow_z[i]) - longint'(shadow_z[c.atom_index]);
                  len = int_sqrt(dx * dx + dy * dy + dz * dz);
                  if (len < best) best = len;
               end
            end
            if (best > longint'(cap_dist)) best = cap_dist;
            d = 32'(best);
            r.red = blend(near_rgb[0], far_rgb[0], d, cap_dist);
            r.green = blend(near_rgb[1], far_rgb[1], d, cap_dist);
            r.blue = blend(near_rgb[2], far_rgb[2], d, cap_dist);
            r.nearest_distance = d[DIST_W-1:0];
            r.overflowed = shadow_overflow;
            expected_colors.push_back(r);
         end
         default: ;
      endcase
   endfunction

   // stall sampled at the rising edge decides whether the last transaction moved
   logic req_stall_q = 1'b0;

   // driver: present queued transactions, with random gaps
   int send_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!(req_valid && req_stall_q)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               atom_cmd_type c;
               c = pending_cmds.pop_front();
               req_command <= c.command;
               req_pos_x <= c.pos_x;
               req_pos_y <= c.pos_y;
               req_pos_z <= c.pos_z;
               req_molecule_id <= c.molecule_id;
               req_atom_index <= c.atom_index;
               req_valid <= 1'b1;
               if (!quiet_phase && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 9);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      req_stall_q <= req_stall;
      if (!reset && req_valid && !req_stall) begin
         atom_cmd_type c;
         c.command = req_command;
         c.pos_x = req_pos_x;
         c.pos_y = req_pos_y;
         c.pos_z = req_pos_z;
         c.molecule_id = req_molecule_id;
         c.atom_index = req_atom_index;
         predict_color(c);
      end
   end

   // receiver: random stall bursts
   int stall_left = 0;
   always @(negedge clock) begin
      if (quiet_phase) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_colors.size() == 0) begin
            $error("result with no expectation waiting");
            error_count++;
         end else begin
            atom_color_type e;
            e = expected_colors.pop_front();
            if (rsp_red !== e.red) begin
               $error("red exp %0d got %0d", e.red, rsp_red);
               error_count++;
            end
            if (rsp_green !== e.green) begin
               $error("green exp %0d got %0d", e.green, rsp_green);
               error_count++;
            end
            if (rsp_blue !== e.blue) begin
               $error("blue exp %0d got %0d", e.blue, rsp_blue);
               error_count++;
            end
            if (rsp_nearest_distance !== e.nearest_distance) begin
               $error("nearest_distance exp %0d got %0d", e.nearest_distance,
                      rsp_nearest_distance);
               error_count++;
            end
            if (rsp_found !== e.found) begin
               $error("found exp %0d got %0d", e.found, rsp_found);
               error_count++;
            end
            if (rsp_overflowed !== e.overflowed) begin
               $error("overflowed exp %0d got %0d", e.overflowed, rsp_overflowed);
               error_count++;
            end
         end
      end
   end

   function automatic atom_cmd_type make_cmd(logic [1:0] op, int x, int y, int z,
                                             int mol, int idx);
      atom_cmd_type c;
      c.command = op;
      c.pos_x = x[POS_W-1:0];
      c.pos_y = y[POS_W-1:0];
      c.pos_z = z[POS_W-1:0];
      c.molecule_id = mol[MOL_W-1:0];
      c.atom_index = idx[IDX_W-1:0];
      return c;
   endfunction

   function automatic atom_cmd_type random_atom(int unsigned spread, int unsigned mols);
      int unsigned s;
      s = spread;
      return make_cmd(CMD_LOAD, int'($urandom_range(0, 2 * s)) - int'(s),
                      int'($urandom_range(0, 2 * s)) - int'(s),
                      int'($urandom_range(0, 2 * s)) - int'(s),
                      $urandom_range(0, mols), $urandom());
   endfunction

   task automatic drain();
      while (pending_cmds.size() > 0 || expected_colors.size() > 0 || req_valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= ADDR_W'({index, 2'b00});
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         REG_MAX_DIST: cap_dist = value[DIST_W-1:0];
         REG_NEAR_RED: near_rgb[0] = value[7:0];
         REG_NEAR_GREEN: near_rgb[1] = value[7:0];
         REG_NEAR_BLUE: near_rgb[2] = value[7:0];
         REG_FAR_RED: far_rgb[0] = value[7:0];
         REG_FAR_GREEN: far_rgb[1] = value[7:0];
         REG_FAR_BLUE: far_rgb[2] = value[7:0];
         default: ;
      endcase
   endtask

   task automatic random_colors();
      write_reg(REG_NEAR_RED, $urandom());
      write_reg(REG_NEAR_GREEN, $urandom());
      write_reg(REG_NEAR_BLUE, $urandom());
      write_reg(REG_FAR_RED, $urandom());
      write_reg(REG_FAR_GREEN, $urandom());
      write_reg(REG_FAR_BLUE, $urandom());
   endtask

   initial begin
      int n;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, own molecule only, unknown index, unused command
      pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_LOAD, -8388608, -8388608, -8388608, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_LOAD, 8388607, 8388607, 8388607, 65535, 255));
      pending_cmds.push_back(make_cmd(CMD_LOAD, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_LOAD, 100, -50, 7, 65535, 0));
      pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 0, 0, 2));
      pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 0, 0, 255));
      pending_cmds.push_back(make_cmd(2'd3, -1, -1, -1, 65535, 255));
      pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 0, 0, 3));
      pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 0, 0, 0));
      drain();

      // extremes of the cap: zero and full
      write_reg(REG_MAX_DIST, 0);
      write_reg(REG_NEAR_RED, 255);
      write_reg(REG_FAR_BLUE, 255);
      pending_cmds.push_back(make_cmd(CMD_LOAD, 1, 2, 3, 1, 0));
      pending_cmds.push_back(make_cmd(CMD_LOAD, 900, 2, 3, 2, 0));
      pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 0, 0, 0));
      drain();
      write_reg(REG_MAX_DIST, 65535);
      pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 0, 0, 1));
      drain();

      // fill the table past full, then query a few entries
      pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0));
      for (int i = 0; i < TABLE_DEPTH + 3; i++) pending_cmds.push_back(random_atom(4000, 7));
      for (int i = 0; i < 4; i++)
         pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 0, 0, $urandom_range(0, 255)));
      drain();

      // random phases: small tables, varied registers
      for (int phase = 0; phase < 12; phase++) begin
         if (phase == 11) quiet_phase = 1'b1;
         case (phase % 4)
            0: write_reg(REG_MAX_DIST, 1);
            1: write_reg(REG_MAX_DIST, $urandom_range(1, 65535));
            2: write_reg(REG_MAX_DIST, 2560);
            default: write_reg(REG_MAX_DIST, $urandom_range(100, 3000));
         endcase
         random_colors();
         for (int t = 0; t < 6; t++) begin
            pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0));
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
               pending_cmds.push_back(t == 5 ? random_atom(8388607, 65535)
                                             : random_atom(1500, 3));
            for (int i = 0; i < 4; i++) begin
               if ($urandom_range(0, 9) == 0)
                  pending_cmds.push_back(make_cmd(2'($urandom_range(0, 3)), $urandom(),
                                                  $urandom(), $urandom(), $urandom(),
                                                  $urandom()));
               else
                  pending_cmds.push_back(make_cmd(CMD_QUERY, $urandom(), $urandom(),
                                                  $urandom(), $urandom(),
                                                  $urandom_range(0, n)));
            end
         end
         drain();
      end

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule

@@ filelist.f @@
src/nfad_pkg.sv
src/nearest_foreign_atom_distance_color.sv
bench/tb.sv
